// ===== rtl/mexp_pkg.sv =====
// Package for the modular exponentiation core.
// Holds the controller state type and the status struct of the multiply unit.
// No dependencies.
package mexp_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

// ===== rtl/mexp_in_if.sv =====
// Input channel of the modular exponentiation core: base and exponent.
// Valid/ready handshake; no dependencies.
interface mexp_in_if #(
    parameter int OPERAND_BITS = 31
) ();
    logic                    valid;
    logic                    ready;
    logic [OPERAND_BITS-1:0] base_value;
    logic [OPERAND_BITS-1:0] exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink (input valid, input base_value, input exponent_value, output ready);
endinterface

// ===== rtl/mexp_out_if.sv =====
// Output channel of the modular exponentiation core: one residue per transfer.
// Valid/ready handshake; no dependencies.
interface mexp_out_if #(
    parameter int OPERAND_BITS = 31
) ();
    logic                    valid;
    logic                    ready;
    logic [OPERAND_BITS-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink (input valid, input residue, output ready);
endinterface

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: x * y mod m, one multiplier bit per cycle.
// Depends on mexp_pkg for the status struct.
module mexp_mulmod #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OPERAND_BITS-1:0] i_x,
    input  logic [OPERAND_BITS-1:0] i_y,
    input  logic [OPERAND_BITS-1:0] i_m,
    output mexp_pkg::t_mul_status   o_status,
    output logic [OPERAND_BITS-1:0] o_result
);
    localparam int CntW = $clog2(OPERAND_BITS);
    localparam int ExtW = OPERAND_BITS + 3;

    logic [OPERAND_BITS-1:0] r_x;
    logic [OPERAND_BITS-1:0] r_y;
    logic [OPERAND_BITS-1:0] r_m;
    logic [OPERAND_BITS-1:0] r_acc;
    logic [CntW-1:0]         r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [ExtW-1:0]         dbl;
    logic [ExtW-1:0]         dbl_m;
    logic [ExtW-1:0]         sum;
    logic [ExtW-1:0]         sum_m;
    logic [ExtW-1:0]         sum_2m;
    logic [ExtW-1:0]         m_ext;
    logic [OPERAND_BITS-1:0] n_acc;

    // Each step forms (2*acc + bit*x) mod m with all candidates in parallel.
    always_comb begin
        m_ext  = ExtW'(r_m);
        dbl    = ExtW'({r_acc, 1'b0});
        dbl_m  = dbl - m_ext;
        sum    = dbl + ExtW'(r_x);
        sum_m  = sum - m_ext;
        sum_2m = sum - {m_ext[ExtW-2:0], 1'b0};
        if (r_y[OPERAND_BITS-1]) begin
            if (!sum_2m[ExtW-1]) begin
                n_acc = sum_2m[OPERAND_BITS-1:0];
            end else if (!sum_m[ExtW-1]) begin
                n_acc = sum_m[OPERAND_BITS-1:0];
            end else begin
                n_acc = sum[OPERAND_BITS-1:0];
            end
        end else begin
            if (!dbl_m[ExtW-1]) begin
                n_acc = dbl_m[OPERAND_BITS-1:0];
            end else begin
                n_acc = dbl[OPERAND_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
            r_acc <= '0;
            r_cnt <= CntW'(OPERAND_BITS - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[OPERAND_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: controller, config register, output register.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and mexp_mulmod.
// The core computes base^exponent mod modulus by right-to-left square-and-multiply. Every
// modular product goes through one shared bit-serial multiplier; the base is first reduced
// by the same unit as 1 * base mod modulus. A zero exponent gives 1 and a modulus below two
// gives 0. A new item is accepted once the previous one has finished, even while its
// residue still waits in the output register.
module modular_exponentiation_core #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [OPERAND_BITS-1:0] i_cfg_wdata,
    mexp_in_if.sink                 i_in,
    mexp_out_if.source              o_out
);
    mexp_pkg::t_state        r_state;
    mexp_pkg::t_state        n_state;
    logic [OPERAND_BITS-1:0] r_modulus;
    logic [OPERAND_BITS-1:0] r_exp;
    logic [OPERAND_BITS-1:0] n_exp;
    logic [OPERAND_BITS-1:0] r_acc;
    logic [OPERAND_BITS-1:0] n_acc;
    logic [OPERAND_BITS-1:0] r_pow;
    logic [OPERAND_BITS-1:0] n_pow;
    logic [OPERAND_BITS-1:0] r_res;
    logic [OPERAND_BITS-1:0] n_res;
    logic                    r_res_valid;
    logic                    n_res_valid;

    logic                    mul_start;
    logic [OPERAND_BITS-1:0] mul_x;
    logic [OPERAND_BITS-1:0] mul_y;
    logic [OPERAND_BITS-1:0] mul_result;
    mexp_pkg::t_mul_status   mul_st;
    logic                    in_xfer;
    logic                    out_xfer;

    assign i_in.ready  = (r_state == mexp_pkg::S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = o_out.valid && o_out.ready;
    assign o_out.valid = r_res_valid;
    assign o_out.residue = r_res;

    mexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_x      (mul_x),
        .i_y      (mul_y),
        .i_m      (r_modulus),
        .o_status (mul_st),
        .o_result (mul_result)
    );

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_pow       = r_pow;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        mul_start   = 1'b0;
        mul_x       = r_pow;
        mul_y       = r_pow;
        if (out_xfer) begin
            n_res_valid = 1'b0;
        end
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_exp = i_in.exponent_value;
                    if (i_in.exponent_value == '0) begin
                        n_acc   = OPERAND_BITS'(1);
                        n_state = mexp_pkg::S_FINISH;
                    end else if (r_modulus < OPERAND_BITS'(2)) begin
                        n_acc   = '0;
                        n_state = mexp_pkg::S_FINISH;
                    end else begin
                        mul_start = 1'b1;
                        mul_x     = OPERAND_BITS'(1);
                        mul_y     = i_in.base_value;
                        n_state   = mexp_pkg::S_REDUCE;
                    end
                end
            end
            mexp_pkg::S_REDUCE: begin
                if (mul_st.done) begin
                    n_pow   = mul_result;
                    n_acc   = OPERAND_BITS'(1);
                    n_state = mexp_pkg::S_STEP;
                end
            end
            mexp_pkg::S_STEP: begin
                if (r_exp[0]) begin
                    mul_start = 1'b1;
                    mul_x     = r_acc;
                    mul_y     = r_pow;
                    n_state   = mexp_pkg::S_MUL;
                end else begin
                    n_exp = {1'b0, r_exp[OPERAND_BITS-1:1]};
                    if (r_exp[OPERAND_BITS-1:1] != '0) begin
                        mul_start = 1'b1;
                        n_state   = mexp_pkg::S_SQR;
                    end else begin
                        n_state = mexp_pkg::S_FINISH;
                    end
                end
            end
            mexp_pkg::S_MUL: begin
                if (mul_st.done) begin
                    n_acc = mul_result;
                    n_exp = {1'b0, r_exp[OPERAND_BITS-1:1]};
                    if (r_exp[OPERAND_BITS-1:1] != '0) begin
                        mul_start = 1'b1;
                        n_state   = mexp_pkg::S_SQR;
                    end else begin
                        n_state = mexp_pkg::S_FINISH;
                    end
                end
            end
            mexp_pkg::S_SQR: begin
                if (mul_st.done) begin
                    n_pow   = mul_result;
                    n_state = mexp_pkg::S_STEP;
                end
            end
            mexp_pkg::S_FINISH: begin
                if (!r_res_valid || o_out.ready) begin
                    n_res       = r_acc;
                    n_res_valid = 1'b1;
                    n_state     = mexp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::S_IDLE;
            r_res_valid <= 1'b0;
            r_modulus   <= OPERAND_BITS'(2);
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_pow <= n_pow;
        r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_st.done |-> (r_state == mexp_pkg::S_REDUCE || r_state == mexp_pkg::S_MUL
                         || r_state == mexp_pkg::S_SQR))
        else $error("multiplier finished outside a wait state");
    a_ready_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !mul_st.busy)
        else $error("input ready while multiplier busy");
    a_step_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_STEP) |-> (r_exp != '0))
        else $error("exponent exhausted in step state");
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_FINISH && o_out.ready) |=> r_res_valid)
        else $error("finished result not loaded into output register");
`endif

endmodule

// ===== verif/modular_exponentiation_core_test.sv =====
// Self-checking testbench for modular_exponentiation_core: base^exponent mod modulus.
// Drives the input and output interfaces with random gaps and stalls and scores each residue.
// Depends on mexp_in_if, mexp_out_if and modular_exponentiation_core.
module modular_exponentiation_core_test;

    localparam int OPERAND_BITS = 31;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 32;

    typedef logic [OPERAND_BITS-1:0] t_operand;

    localparam t_operand MAX_VALUE = '1;

    class residue_scoreboard;
        t_operand modulus;
        t_operand residue_q[$];
        int errors;

        function new();
            modulus = t_operand'(2);
            errors = 0;
        endfunction

        function t_operand power_mod(t_operand base_value, t_operand exponent_value);
            longint unsigned m;
            longint unsigned power;
            longint unsigned acc;
            t_operand bits_left;
            if (exponent_value == 0) begin
                return t_operand'(1);
            end
            if (modulus < 2) begin
                return '0;
            end
            m = 64'(modulus);
            power = 64'(base_value) % m;
            acc = 64'd1;
            bits_left = exponent_value;
            while (bits_left != 0) begin
                if (bits_left[0]) begin
                    acc = (acc * power) % m;
                end
                bits_left = bits_left >> 1;
                if (bits_left != 0) begin
                    power = (power * power) % m;
                end
            end
            return t_operand'(acc);
        endfunction

        function void note_input(t_operand base_value, t_operand exponent_value);
            residue_q.push_back(power_mod(base_value, exponent_value));
        endfunction

        function void check_residue(t_operand residue);
            t_operand expected;
            if (residue_q.size() == 0) begin
                $display("%0t: residue %0d transferred with no residue expected",
                         $time, residue);
                errors++;
            end else begin
                expected = residue_q.pop_front();
                if (residue !== expected) begin
                    $display("%0t: residue mismatch, expected %0d, actual %0d",
                             $time, expected, residue);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return residue_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_operand i_cfg_wdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    t_operand phase_modulus;

    residue_scoreboard residues = new();

    mexp_in_if #(.OPERAND_BITS(OPERAND_BITS)) in_if ();
    mexp_out_if #(.OPERAND_BITS(OPERAND_BITS)) out_if ();

    modular_exponentiation_core #(
        .OPERAND_BITS(OPERAND_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_if),
        .o_out(out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            residues.check_residue(out_if.residue);
        end
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                send_idle_pct = 86;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 86;
            end
            3: begin
                send_idle_pct = 22;
                recv_stall_pct = 22;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic drain_residues();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (residues.pending() != 0);
    endtask

    // A new modulus is written only once every residue has been transferred.
    task automatic write_modulus(input t_operand value);
        drain_residues();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        residues.modulus = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input t_operand base_value, input t_operand exponent_value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.base_value <= base_value;
        in_if.exponent_value <= exponent_value;
        do @(posedge i_clk); while (!in_if.ready);
        residues.note_input(base_value, exponent_value);
    endtask

    function automatic t_operand random_base();
        t_operand value;
        case ($urandom_range(0, 3))
            0: value = t_operand'($urandom);
            1: value = t_operand'($urandom_range(0, 15));
            2: value = residues.modulus + t_operand'($urandom_range(0, 4)) - t_operand'(2);
            default: value = MAX_VALUE - t_operand'($urandom_range(0, 3));
        endcase
        return value;
    endfunction

    // Most exponents are cut to a random bit length so that the run stays short.
    function automatic t_operand random_exponent();
        t_operand value;
        int len;
        case ($urandom_range(0, 9))
            0: value = '0;
            1: value = t_operand'($urandom);
            default: begin
                len = $urandom_range(1, OPERAND_BITS);
                value = t_operand'($urandom) & (MAX_VALUE >> (OPERAND_BITS - len));
            end
        endcase
        return value;
    endfunction

    task automatic random_phase(input t_operand modulus, input int mode);
        set_idling(mode);
        write_modulus(modulus);
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) begin
                drain_residues();
            end
            send_item(random_base(), random_exponent());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        in_if.valid <= 1'b0;
        in_if.base_value <= '0;
        in_if.exponent_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(t_operand'(5), '0);
        send_item(MAX_VALUE, MAX_VALUE);
        send_item('0, t_operand'(7));
        send_item(t_operand'(6), t_operand'(1));

        write_modulus(MAX_VALUE);
        send_item('0, '0);
        send_item('0, t_operand'(1));
        send_item('0, MAX_VALUE);
        send_item(MAX_VALUE, '0);
        send_item(MAX_VALUE, t_operand'(1));
        send_item(MAX_VALUE - t_operand'(1), MAX_VALUE);
        send_item(MAX_VALUE - t_operand'(1), t_operand'(2));
        send_item(t_operand'(2), MAX_VALUE);
        send_item(t_operand'(1), MAX_VALUE);
        send_item(31'h2AAAAAAA, 31'h55555555);
        send_item(31'h55555555, 31'h2AAAAAAA);

        write_modulus('0);
        send_item(t_operand'(7), '0);
        send_item(t_operand'(7), t_operand'(5));
        send_item(MAX_VALUE, MAX_VALUE);

        write_modulus(t_operand'(1));
        send_item('0, '0);
        send_item(MAX_VALUE, t_operand'(1));
        send_item(t_operand'(3), MAX_VALUE);

        write_modulus(t_operand'(3));
        send_item(t_operand'(10), t_operand'(3));
        send_item(MAX_VALUE, t_operand'(2));
        send_item(t_operand'(2), MAX_VALUE);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: phase_modulus = MAX_VALUE;
                1: phase_modulus = t_operand'($urandom) | t_operand'(31'h40000000);
                2: phase_modulus = t_operand'($urandom_range(2, 1000));
                3: phase_modulus = t_operand'(2);
                4: phase_modulus = MAX_VALUE - t_operand'(1);
                5: phase_modulus = t_operand'($urandom_range(0, 1));
                6: phase_modulus = t_operand'($urandom);
                default: phase_modulus = MAX_VALUE;
            endcase
            random_phase(phase_modulus, p % 4);
        end

        drain_residues();
        repeat (40) @(posedge i_clk);
        if (residues.pending() != 0) begin
            $display("%0t: %0d expected residues never transferred", $time, residues.pending());
            residues.errors++;
        end
        if (residues.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
